// ----- src/mesf_pkg.sv -----
`timescale 1ns / 1ps

package mesf_pkg;

   localparam int MAX_RADIUS_DEF = 31;
   localparam int SPAN_CAP       = 63;

   localparam int COORD_W  = 11;
   localparam int OUT_W    = 12;
   localparam int RADIUS_W = 5;
   localparam int HEIGHT_W = 6;
   localparam int COLOR_W  = 16;

   localparam int SQ_W     = 2 * RADIUS_W;
   localparam int PRODRY_W = 15;
   localparam int PRODRR_W = 2 * SQ_W;
   localparam int PX_W     = 17;
   localparam int PY_W     = 16;
   localparam int X_W      = 6;
   localparam int N_W      = 6;
   localparam int SQR_W    = 14;
   localparam int P_W      = 32;

   localparam logic signed [P_W-1:0] ROUND4 = P_W'(3);

   typedef struct packed {
      logic signed [COORD_W-1:0]  cx;
      logic signed [COORD_W-1:0]  cy;
      logic [COLOR_W-1:0]         color;
      logic [RADIUS_W-1:0]        ry;
      logic [SQ_W-1:0]            rx2;
      logic [SQ_W-1:0]            ry2;
      logic [PRODRR_W-1:0]        rx2ry2;
      logic [PY_W-1:0]            py0;
      logic signed [P_W-1:0]      p1;
   } job_type;

   typedef struct packed {
      logic signed [OUT_W-1:0]    x_left;
      logic signed [OUT_W-1:0]    x_right;
      logic signed [OUT_W-1:0]    y_top;
      logic [HEIGHT_W-1:0]        height;
      logic [COLOR_W-1:0]         color;
      logic                       last;
   } span_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_SQX,
      F_SQY,
      F_PROD,
      F_PROD2,
      F_SUM,
      F_TRUNC,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_CENTER,
      B_R1,
      B_M1,
      B_M2,
      B_M3,
      B_M4,
      B_M5,
      B_M6,
      B_R2
   } back_state_type;

   // divide by four, rounding toward zero
   function automatic logic signed [P_W-1:0] trunc4(input logic signed [P_W-1:0] v);
      logic signed [P_W-1:0] t;
      t = v[P_W-1] ? (v + ROUND4) : v;
      return t >>> 2;
   endfunction

endpackage

// ----- src/mesf_fifo.sv -----
`timescale 1ns / 1ps

module mesf_fifo #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int CNT_W = 2;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [WIDTH-1:0] slot0_ff, slot0_in;
   logic [WIDTH-1:0] slot1_ff, slot1_in;
   logic             do_push, do_pop;

   always_comb begin
      do_push  = push && (count_ff != CNT_FULL);
      do_pop   = pop && (count_ff != '0);
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (do_pop) begin
         slot0_in = slot1_ff;
      end
      if (do_push) begin
         if ((count_ff == '0) || ((count_ff == CNT_ONE) && do_pop)) begin
            slot0_in = din;
         end else begin
            slot1_in = din;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign dout  = slot0_ff;

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty) else $error("queue full and empty at once");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> !empty) else $error("accepted word lost");

   a_last_pop: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !push && count_ff == CNT_ONE) |=> empty)
      else $error("queue not drained by last pop");

endmodule

// ----- src/mesf_front.sv -----
`timescale 1ns / 1ps

module mesf_front #(
   parameter int MAX_RADIUS = mesf_pkg::MAX_RADIUS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [mesf_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [mesf_pkg::COORD_W-1:0]  req_center_y,
   input  logic [mesf_pkg::RADIUS_W-1:0]        req_radius_x,
   input  logic [mesf_pkg::RADIUS_W-1:0]        req_radius_y,
   input  logic [mesf_pkg::COLOR_W-1:0]         req_color,
   output logic                                 job_push,
   output mesf_pkg::job_type                    job,
   input  logic                                 job_full
);

   import mesf_pkg::*;

   localparam int MUL_W = 2 * SQ_W;
   localparam logic [RADIUS_W-1:0] RMAX = RADIUS_W'(MAX_RADIUS);

   front_state_type            state_ff, state_in;
   logic signed [COORD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [COLOR_W-1:0]         col_ff, col_in;
   logic [RADIUS_W-1:0]        rx_ff, rx_in, ry_ff, ry_in;
   logic [SQ_W-1:0]            rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [PRODRY_W-1:0]        rx2ry_ff, rx2ry_in;
   logic [PRODRR_W-1:0]        rx2ry2_ff, rx2ry2_in;
   logic signed [P_W-1:0]      q_ff, q_in, p1_ff, p1_in;
   logic [SQ_W-1:0]            mul_a, mul_b;
   logic [MUL_W-1:0]           prod;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         F_SQX: begin
            mul_a = SQ_W'(rx_ff);
            mul_b = SQ_W'(rx_ff);
         end
         F_SQY: begin
            mul_a = SQ_W'(ry_ff);
            mul_b = SQ_W'(ry_ff);
         end
         F_PROD: begin
            mul_a = rx2_ff;
            mul_b = SQ_W'(ry_ff);
         end
         F_PROD2: begin
            mul_a = rx2_ff;
            mul_b = ry2_ff;
         end
         default: ;
      endcase
      prod = MUL_W'(mul_a) * MUL_W'(mul_b);
   end

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      col_in    = col_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rx2_in    = rx2_ff;
      ry2_in    = ry2_ff;
      rx2ry_in  = rx2ry_ff;
      rx2ry2_in = rx2ry2_ff;
      q_in      = q_ff;
      p1_in     = p1_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               cx_in  = req_center_x;
               cy_in  = req_center_y;
               col_in = req_color;
               rx_in  = (req_radius_x > RMAX) ? RMAX : req_radius_x;
               ry_in  = (req_radius_y > RMAX) ? RMAX : req_radius_y;
            end
         end
         F_SQX:   rx2_in    = prod[SQ_W-1:0];
         F_SQY:   ry2_in    = prod[SQ_W-1:0];
         F_PROD:  rx2ry_in  = prod[PRODRY_W-1:0];
         F_PROD2: rx2ry2_in = prod[PRODRR_W-1:0];
         F_SUM:   q_in = P_W'({ry2_ff, 2'b00}) + P_W'(rx2_ff) - P_W'({rx2ry_ff, 2'b00});
         F_TRUNC: p1_in = trunc4(q_ff);
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (req_push) state_in = F_SQX;
         F_SQX:   state_in = F_SQY;
         F_SQY:   state_in = F_PROD;
         F_PROD:  state_in = F_PROD2;
         F_PROD2: state_in = F_SUM;
         F_SUM:   state_in = F_TRUNC;
         F_TRUNC: state_in = F_PUSH;
         F_PUSH:  if (!job_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_full   = 1'b1;
      job_push   = 1'b0;
      job.cx     = cx_ff;
      job.cy     = cy_ff;
      job.color  = col_ff;
      job.ry     = ry_ff;
      job.rx2    = rx2_ff;
      job.ry2    = ry2_ff;
      job.rx2ry2 = rx2ry2_ff;
      job.py0    = {rx2ry_ff, 1'b0};
      job.p1     = p1_ff;
      unique case (state_ff)
         F_IDLE:  req_full = 1'b0;
         F_PUSH:  job_push = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      col_ff    <= col_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rx2_ff    <= rx2_in;
      ry2_ff    <= ry2_in;
      rx2ry_ff  <= rx2ry_in;
      rx2ry2_ff <= rx2ry2_in;
      q_ff      <= q_in;
      p1_ff     <= p1_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> (state_ff == F_SQX))
      else $error("accepted request did not start setup");

   a_radius_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != F_IDLE) |-> (rx_ff <= RMAX && ry_ff <= RMAX))
      else $error("radius above limit");

   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      (job_push && job_full) |=> (state_ff == F_PUSH && $stable(p1_ff)))
      else $error("stalled job not held");

endmodule

// ----- src/mesf_back.sv -----
`timescale 1ns / 1ps

module mesf_back (
   input  logic               clock,
   input  logic               reset,
   input  mesf_pkg::job_type  job,
   input  logic               job_empty,
   output logic               job_pop,
   output mesf_pkg::span_type span,
   output logic               span_push,
   input  logic               span_full
);

   import mesf_pkg::*;

   localparam int MUL_W = SQ_W + SQR_W;
   localparam logic [N_W-1:0] NCAP = N_W'(SPAN_CAP);

   back_state_type             state_ff, state_in;
   logic signed [COORD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [COLOR_W-1:0]         col_ff, col_in;
   logic [SQ_W-1:0]            rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [PRODRR_W-1:0]        rx2ry2_ff, rx2ry2_in;
   logic [X_W-1:0]             x_ff, x_in, x_step;
   logic [RADIUS_W-1:0]        y_ff, y_in, y_step;
   logic [PX_W-1:0]            px_ff, px_in, px_step;
   logic [PY_W-1:0]            py_ff, py_in, py_step;
   logic signed [P_W-1:0]      p_ff, p_in, p_step;
   logic signed [P_W-1:0]      acc_ff, acc_in;
   logic [SQR_W-1:0]           sq_ff, sq_in;
   logic [N_W-1:0]             n_ff, n_in, n_step;
   logic                       last_step;
   logic [SQ_W:0]              two_rx2, two_ry2;
   logic [SQ_W-1:0]            mul_a;
   logic [SQR_W-1:0]           mul_b;
   logic [MUL_W-1:0]           prod;
   logic                       emit;

   assign two_rx2 = {rx2_ff, 1'b0};
   assign two_ry2 = {ry2_ff, 1'b0};

   always_comb begin
      n_step    = n_ff + N_W'(1);
      x_step    = x_ff;
      y_step    = y_ff;
      px_step   = px_ff;
      py_step   = py_ff;
      p_step    = p_ff;
      last_step = 1'b0;
      case (state_ff)
         B_R1: begin
            x_step  = x_ff + X_W'(1);
            px_step = px_ff + PX_W'(two_ry2);
            if (p_ff[P_W-1]) begin
               p_step = p_ff + P_W'(ry2_ff) + P_W'(px_step);
            end else begin
               y_step  = y_ff - RADIUS_W'(1);
               py_step = py_ff - PY_W'(two_rx2);
               p_step  = p_ff + P_W'(ry2_ff) + P_W'(px_step) - P_W'(py_step);
            end
            last_step = (n_step == NCAP)
                     || (!(px_step < PX_W'(py_step)) && (y_step == '0));
         end
         B_R2: begin
            y_step  = y_ff - RADIUS_W'(1);
            py_step = py_ff - PY_W'(two_rx2);
            if (!p_ff[P_W-1] && (p_ff != '0)) begin
               p_step = p_ff + P_W'(rx2_ff) - P_W'(py_step);
            end else begin
               x_step  = x_ff + X_W'(1);
               px_step = px_ff + PX_W'(two_ry2);
               p_step  = p_ff + P_W'(rx2_ff) - P_W'(py_step) + P_W'(px_step);
            end
            last_step = (n_step == NCAP) || (y_step == '0);
         end
         default: ;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         B_M1: begin
            mul_a = SQ_W'({x_ff, 1'b1});
            mul_b = SQR_W'({x_ff, 1'b1});
         end
         B_M2: begin
            mul_a = ry2_ff;
            mul_b = sq_ff;
         end
         B_M3: begin
            mul_a = SQ_W'(y_ff - RADIUS_W'(1));
            mul_b = SQR_W'(y_ff - RADIUS_W'(1));
         end
         B_M4: begin
            mul_a = rx2_ff;
            mul_b = sq_ff;
         end
         default: ;
      endcase
      prod = MUL_W'(mul_a) * MUL_W'(mul_b);
   end

   always_comb begin
      span.color   = col_ff;
      span.x_left  = OUT_W'(cx_ff) - OUT_W'(x_step);
      span.x_right = OUT_W'(cx_ff) + OUT_W'(x_step);
      span.y_top   = OUT_W'(cy_ff) - OUT_W'(y_step);
      span.height  = {y_step, 1'b0};
      span.last    = (state_ff == B_CENTER) ? (y_ff == '0) : last_step;
   end

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      col_in    = col_ff;
      rx2_in    = rx2_ff;
      ry2_in    = ry2_ff;
      rx2ry2_in = rx2ry2_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      p_in      = p_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      n_in      = n_ff;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               cx_in     = job.cx;
               cy_in     = job.cy;
               col_in    = job.color;
               rx2_in    = job.rx2;
               ry2_in    = job.ry2;
               rx2ry2_in = job.rx2ry2;
               x_in      = '0;
               y_in      = job.ry;
               px_in     = '0;
               py_in     = job.py0;
               p_in      = job.p1;
               n_in      = '0;
            end
         end
         B_CENTER: begin
            if (!span_full) n_in = n_step;
         end
         B_R1, B_R2: begin
            if (!span_full) begin
               x_in  = x_step;
               y_in  = y_step;
               px_in = px_step;
               py_in = py_step;
               p_in  = p_step;
               n_in  = n_step;
            end
         end
         B_M1:    sq_in  = prod[SQR_W-1:0];
         B_M2:    acc_in = P_W'(prod);
         B_M3:    sq_in  = prod[SQR_W-1:0];
         B_M4:    acc_in = acc_ff + P_W'({prod, 2'b00});
         B_M5:    acc_in = acc_ff - P_W'({rx2ry2_ff, 2'b00});
         B_M6:    p_in   = trunc4(acc_ff);
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!job_empty) state_in = B_CENTER;
         B_CENTER: begin
            if (!span_full) begin
               if (y_ff == '0) begin
                  state_in = B_IDLE;
               end else if (py_ff != '0) begin
                  state_in = B_R1;
               end else begin
                  state_in = B_M1;
               end
            end
         end
         B_R1: begin
            if (!span_full) begin
               if (last_step) begin
                  state_in = B_IDLE;
               end else if (!(px_step < PX_W'(py_step))) begin
                  state_in = B_M1;
               end
            end
         end
         B_M1: state_in = B_M2;
         B_M2: state_in = B_M3;
         B_M3: state_in = B_M4;
         B_M4: state_in = B_M5;
         B_M5: state_in = B_M6;
         B_M6: state_in = B_R2;
         B_R2: if (!span_full && last_step) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      job_pop = 1'b0;
      emit    = 1'b0;
      unique case (state_ff)
         B_IDLE:             job_pop = !job_empty;
         B_CENTER, B_R1, B_R2: emit  = !span_full;
         default: ;
      endcase
      span_push = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      col_ff    <= col_in;
      rx2_ff    <= rx2_in;
      ry2_ff    <= ry2_in;
      rx2ry2_ff <= rx2ry2_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      p_ff      <= p_in;
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      n_ff      <= n_in;
   end

   a_r1_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_R1) |-> (px_ff < PX_W'(py_ff)))
      else $error("region one entered with px not below py");

   a_r2_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_R2) |-> (y_ff != '0))
      else $error("region two entered at y zero");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (span_push && !span_full && span.last) |=> (state_ff == B_IDLE))
      else $error("span walk continued past last word");

   a_setup_under_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_M1) |-> (n_ff < NCAP))
      else $error("region two setup after span cap");

endmodule

// ----- src/midpoint_ellipse_span_fill.sv -----
`timescale 1ns / 1ps
// Filled-ellipse span generator.
// Request channel (req_*): push a word holding centre, radii and colour
// while req_full is low. Radii above MAX_RADIUS are clamped.
// Response channel (rsp_*): while rsp_empty is low the oldest span word
// is on the rsp_ ports; rsp_pop takes it. The first word of a request is
// the centre column, each later word a mirrored column pair with its top
// row and height; rsp_last marks the final word (at most 63 per request).
// Path: the front setup states (squares, products, sum, truncation) push
// a job into the job queue; the back takes it, then emits the centre word.
// Throughput: one span word per cycle while the response queue is not full;
// the walk adds an idle state per request and the region-two setup steps
// (B_M1 to B_M6) on the back's shared multiplier. Setup of the next
// request overlaps the current walk through a two-word job queue.
// Reset clears all control state; no request is in flight afterward.
// When the receiver stalls, the span walk holds and the two-word response
// queue keeps the pending words; no word is dropped or repeated.
module midpoint_ellipse_span_fill #(
   parameter int MAX_RADIUS = mesf_pkg::MAX_RADIUS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [mesf_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [mesf_pkg::COORD_W-1:0]  req_center_y,
   input  logic [mesf_pkg::RADIUS_W-1:0]        req_radius_x,
   input  logic [mesf_pkg::RADIUS_W-1:0]        req_radius_y,
   input  logic [mesf_pkg::COLOR_W-1:0]         req_color,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [mesf_pkg::OUT_W-1:0]    rsp_x_left,
   output logic signed [mesf_pkg::OUT_W-1:0]    rsp_x_right,
   output logic signed [mesf_pkg::OUT_W-1:0]    rsp_y_top,
   output logic [mesf_pkg::HEIGHT_W-1:0]        rsp_height,
   output logic [mesf_pkg::COLOR_W-1:0]         rsp_span_color,
   output logic                                 rsp_last
);

   import mesf_pkg::*;

   job_type  job_in_word, job_out_word;
   span_type span_in_word, span_out_word;
   logic     job_push, job_full, job_pop, job_empty;
   logic     span_push, span_full;

   mesf_front #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius_x (req_radius_x),
      .req_radius_y (req_radius_y),
      .req_color    (req_color),
      .job_push     (job_push),
      .job          (job_in_word),
      .job_full     (job_full)
   );

   mesf_fifo #(
      .WIDTH ($bits(job_type))
   ) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in_word),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (job_out_word),
      .empty (job_empty)
   );

   mesf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_out_word),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .span      (span_in_word),
      .span_push (span_push),
      .span_full (span_full)
   );

   mesf_fifo #(
      .WIDTH ($bits(span_type))
   ) u_span_queue (
      .clock (clock),
      .reset (reset),
      .push  (span_push),
      .din   (span_in_word),
      .full  (span_full),
      .pop   (rsp_pop),
      .dout  (span_out_word),
      .empty (rsp_empty)
   );

   assign rsp_x_left     = span_out_word.x_left;
   assign rsp_x_right    = span_out_word.x_right;
   assign rsp_y_top      = span_out_word.y_top;
   assign rsp_height     = span_out_word.height;
   assign rsp_span_color = span_out_word.color;
   assign rsp_last       = span_out_word.last;

endmodule

// ----- sim/tb_midpoint_ellipse_span_fill.sv -----
`timescale 1ns / 1ps

module tb_midpoint_ellipse_span_fill;
   import mesf_pkg::*;

   localparam int MAX_RADIUS  = MAX_RADIUS_DEF;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 40;
   localparam int PRINT_CAP   = 50;

   typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;

   typedef struct {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [RADIUS_W-1:0]       rx;
      logic [RADIUS_W-1:0]       ry;
      logic [COLOR_W-1:0]        color;
      bit                        hold;
      pace_type                  pace;
   } ellipse_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_push = 1'b0;
   logic                       req_full;
   logic signed [COORD_W-1:0]  req_center_x = '0;
   logic signed [COORD_W-1:0]  req_center_y = '0;
   logic [RADIUS_W-1:0]        req_radius_x = '0;
   logic [RADIUS_W-1:0]        req_radius_y = '0;
   logic [COLOR_W-1:0]         req_color = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic signed [OUT_W-1:0]    rsp_x_left;
   logic signed [OUT_W-1:0]    rsp_x_right;
   logic signed [OUT_W-1:0]    rsp_y_top;
   logic [HEIGHT_W-1:0]        rsp_height;
   logic [COLOR_W-1:0]         rsp_span_color;
   logic                       rsp_last;

   ellipse_req_type ellipse_queue[$];
   span_type        span_expect[$];
   ellipse_req_type cur_ellipse;
   pace_type        cur_pace = PACE_FREE;
   int              total_ellipses = 0;
   int              ellipses_taken = 0;
   int              spans_seen = 0;
   int              fail_count = 0;
   int              quiet_cycles = 0;
   bit              drive_go;
   span_type        want_span;

   midpoint_ellipse_span_fill #(.MAX_RADIUS(MAX_RADIUS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius_x   (req_radius_x),
      .req_radius_y   (req_radius_y),
      .req_color      (req_color),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_x_left     (rsp_x_left),
      .rsp_x_right    (rsp_x_right),
      .rsp_y_top      (rsp_y_top),
      .rsp_height     (rsp_height),
      .rsp_span_color (rsp_span_color),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   function automatic int send_idle_pct(pace_type p);
      case (p)
         PACE_SEND_IDLE: return 88;
         PACE_BOTH:      return 9;
         default:        return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(pace_type p);
      case (p)
         PACE_RECV_STALL: return 88;
         PACE_BOTH:       return 9;
         default:         return 0;
      endcase
   endfunction

   function automatic void add_span(longint xl, longint xr, longint yt, longint h,
                                    logic [COLOR_W-1:0] c);
      span_type s;
      s.x_left  = xl[OUT_W-1:0];
      s.x_right = xr[OUT_W-1:0];
      s.y_top   = yt[OUT_W-1:0];
      s.height  = h[HEIGHT_W-1:0];
      s.color   = c;
      s.last    = 1'b0;
      span_expect.push_back(s);
   endfunction

   function automatic void predict_ellipse_spans(ellipse_req_type r);
      longint cx, cy, rx, ry, rx2, ry2, two_rx2, two_ry2, p, x, y, px, py;
      int n;
      span_type s;
      cx = r.cx;
      cy = r.cy;
      rx = r.rx;
      ry = r.ry;
      if (rx > MAX_RADIUS) rx = MAX_RADIUS;
      if (ry > MAX_RADIUS) ry = MAX_RADIUS;
      rx2 = rx * rx;
      ry2 = ry * ry;
      two_rx2 = 2 * rx2;
      two_ry2 = 2 * ry2;
      x = 0;
      y = ry;
      px = 0;
      py = two_rx2 * y;
      n = 0;
      add_span(cx, cx, cy - y, 2 * y, r.color);
      n++;
      p = (4 * ry2 - 4 * rx2 * ry + rx2) / 4;
      while (px < py && n < SPAN_CAP) begin
         x++;
         px += two_ry2;
         if (p < 0) begin
            p += ry2 + px;
         end else begin
            y--;
            py -= two_rx2;
            p += ry2 + px - py;
         end
         add_span(cx - x, cx + x, cy - y, 2 * y, r.color);
         n++;
      end
      p = (ry2 * (2 * x + 1) * (2 * x + 1) + 4 * rx2 * (y - 1) * (y - 1)
           - 4 * rx2 * ry2) / 4;
      while (y > 0 && n < SPAN_CAP) begin
         y--;
         py -= two_rx2;
         if (p > 0) begin
            p += rx2 - py;
         end else begin
            x++;
            px += two_ry2;
            p += rx2 - py + px;
         end
         add_span(cx - x, cx + x, cy - y, 2 * y, r.color);
         n++;
      end
      s = span_expect.pop_back();
      s.last = 1'b1;
      span_expect.push_back(s);
   endfunction

   task automatic report_mismatch(string what, logic [COLOR_W-1:0] got,
                                  logic [COLOR_W-1:0] want);
      if (fail_count < PRINT_CAP)
         $display("span %0d: %s got %h want %h", spans_seen, what, got, want);
      fail_count++;
   endtask

   task automatic queue_ellipse(int cx, int cy, int rx, int ry, int color, bit hold,
                                pace_type pace);
      ellipse_req_type r;
      r.cx    = cx[COORD_W-1:0];
      r.cy    = cy[COORD_W-1:0];
      r.rx    = rx[RADIUS_W-1:0];
      r.ry    = ry[RADIUS_W-1:0];
      r.color = color[COLOR_W-1:0];
      r.hold  = hold;
      r.pace  = pace;
      ellipse_queue.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_ellipse_spans(cur_ellipse);
            ellipses_taken++;
         end
         if (!(req_push && req_full)) begin
            drive_go = 1'b0;
            if (ellipse_queue.size() != 0) begin
               if (!(ellipse_queue[0].hold && span_expect.size() != 0) &&
                   $urandom_range(99) >= send_idle_pct(ellipse_queue[0].pace))
                  drive_go = 1'b1;
            end
            if (drive_go) begin
               cur_ellipse = ellipse_queue.pop_front();
               cur_pace = cur_ellipse.pace;
               req_center_x <= cur_ellipse.cx;
               req_center_y <= cur_ellipse.cy;
               req_radius_x <= cur_ellipse.rx;
               req_radius_y <= cur_ellipse.ry;
               req_color    <= cur_ellipse.color;
            end
            req_push <= drive_go;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (span_expect.size() == 0) begin
               report_mismatch("unexpected word", {4'b0, rsp_x_left}, '0);
            end else begin
               want_span = span_expect.pop_front();
               if (rsp_x_left !== want_span.x_left)
                  report_mismatch("x_left", {4'b0, rsp_x_left}, {4'b0, want_span.x_left});
               if (rsp_x_right !== want_span.x_right)
                  report_mismatch("x_right", {4'b0, rsp_x_right}, {4'b0, want_span.x_right});
               if (rsp_y_top !== want_span.y_top)
                  report_mismatch("y_top", {4'b0, rsp_y_top}, {4'b0, want_span.y_top});
               if (rsp_height !== want_span.height)
                  report_mismatch("height", {10'b0, rsp_height}, {10'b0, want_span.height});
               if (rsp_span_color !== want_span.color)
                  report_mismatch("span_color", rsp_span_color, want_span.color);
               if (rsp_last !== want_span.last)
                  report_mismatch("last", {15'b0, rsp_last}, {15'b0, want_span.last});
            end
            spans_seen++;
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct(cur_pace));
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int i;
      pace_type p;
      queue_ellipse(0, 0, 0, 0, 'h0000, 1'b0, PACE_FREE);
      queue_ellipse(-1024, -1024, 31, 31, 'hFFFF, 1'b0, PACE_FREE);
      queue_ellipse(1023, 1023, 31, 31, 'h0000, 1'b0, PACE_FREE);
      queue_ellipse(1023, -1024, 0, 31, 'hAAAA, 1'b0, PACE_FREE);
      queue_ellipse(-1024, 1023, 31, 0, 'h5555, 1'b0, PACE_FREE);
      queue_ellipse(0, 0, 0, 1, 'h1234, 1'b0, PACE_FREE);
      queue_ellipse(0, 0, 1, 0, 'h8001, 1'b0, PACE_FREE);
      queue_ellipse(0, 0, 1, 1, 'hFFFF, 1'b0, PACE_FREE);
      queue_ellipse(5, -5, 1, 31, 'h0F0F, 1'b0, PACE_FREE);
      queue_ellipse(-5, 5, 31, 1, 'hF0F0, 1'b0, PACE_FREE);
      queue_ellipse(-1, -1, 21, 10, 'h00FF, 1'b0, PACE_FREE);
      queue_ellipse(1, 1, 10, 21, 'hFF00, 1'b0, PACE_FREE);
      queue_ellipse(100, 200, 2, 3, 'h7FFF, 1'b0, PACE_SEND_IDLE);
      queue_ellipse(-300, 17, 13, 7, 'h4321, 1'b0, PACE_RECV_STALL);
      queue_ellipse(512, -512, 16, 8, 'hBEEF, 1'b0, PACE_BOTH);
      queue_ellipse(-511, 511, 8, 16, 'hCAFE, 1'b0, PACE_FREE);
      queue_ellipse(1020, -1020, 30, 29, 'h0001, 1'b0, PACE_FREE);
      queue_ellipse(-1020, 1020, 0, 0, 'h8000, 1'b0, PACE_FREE);
      queue_ellipse(3, 3, 31, 2, 'h2222, 1'b0, PACE_RECV_STALL);
      queue_ellipse(-3, -3, 2, 31, 'hDDDD, 1'b1, PACE_FREE);
      for (i = 0; i < 130; i++) begin
         p = pace_type'((i / 19) % 4);
         queue_ellipse($signed(11'($urandom_range(2047))), $signed(11'($urandom_range(2047))),
                       $urandom_range(31), $urandom_range(31), $urandom_range(65535),
                       (i == 57 || i == 113), p);
      end
      total_ellipses = ellipse_queue.size();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (ellipses_taken < total_ellipses) @(negedge clock);
      while (span_expect.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/mesf_pkg.sv
src/mesf_fifo.sv
src/mesf_front.sv
src/mesf_back.sv
src/midpoint_ellipse_span_fill.sv
sim/tb_midpoint_ellipse_span_fill.sv
